FILE: sv/hufr_pkg.sv
// hufr_pkg: sizes, widths, record kinds and the result record type shared
// by the tree header rebuild modules; no dependencies
package hufr_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int MAX_NODES   = 512;
    localparam int SYMBOL_BITS = 8;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int ID_W    = 9;
    localparam int SYM_W   = 8;
    localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
    localparam int SP_W    = $clog2(STACK_DEPTH);
    localparam int NODE_W  = $clog2(MAX_NODES + 1);
    localparam int TAKEN_W = $clog2(SYMBOL_BITS + 1);
    localparam int BIT_W   = $clog2(BYTE_W + 1);

    typedef enum logic [KIND_W-1:0] {
        KIND_LEAF  = 2'd0,
        KIND_INNER = 2'd1,
        KIND_DONE  = 2'd2,
        KIND_ERROR = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [ID_W-1:0]  id;
        logic [SYM_W-1:0] sym;
        logic [ID_W-1:0]  left;
        logic [ID_W-1:0]  right;
    } t_rec;

endpackage

FILE: sv/hufr_ram.sv
// hufr_ram: generic single write port, single read port ram with registered
// read data; no dependencies
module hufr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/hufr_in_queue.sv
// hufr_in_queue: front part, two-entry queue of header bytes and stream end
// flags in front of the bit engine; depends on hufr_pkg
module hufr_in_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [hufr_pkg::BYTE_W-1:0] i_header_byte,
    input  logic                       i_stream_end,
    output logic                       o_q_valid,
    input  logic                       i_q_pop,
    output logic [hufr_pkg::BYTE_W-1:0] o_q_byte,
    output logic                       o_q_end
);

    logic [hufr_pkg::BYTE_W-1:0] r_byte [2];
    logic                        r_end  [2];
    logic                        r_wp;
    logic                        r_rp;
    logic [1:0]                  r_cnt;
    logic                        push;
    logic                        pop;

    assign o_stall   = (r_cnt == 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_byte  = r_byte[r_rp];
    assign o_q_end   = r_end[r_rp];
    assign push      = i_valid && !o_stall;
    assign pop       = i_q_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
        if (push) begin
            r_byte[r_wp] <= i_header_byte;
            r_end[r_wp]  <= i_stream_end;
        end
    end

endmodule

FILE: sv/hufr_engine.sv
// hufr_engine: back part, walks header bits one per cycle while not stalled
// or refilling, keeps the node stack (top two entries in registers, the rest
// in hufr_ram), sends records via hold and output registers; uses hufr_pkg
module hufr_engine (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    output logic                        o_q_pop,
    input  logic [hufr_pkg::BYTE_W-1:0] i_q_byte,
    input  logic                        i_q_end,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [hufr_pkg::KIND_W-1:0] o_record_kind,
    output logic [hufr_pkg::ID_W-1:0]   o_node_id,
    output logic [hufr_pkg::SYM_W-1:0]  o_leaf_symbol,
    output logic [hufr_pkg::ID_W-1:0]   o_left_child,
    output logic [hufr_pkg::ID_W-1:0]   o_right_child,
    output logic                        o_run_last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BIT,
        S_POP,
        S_END,
        S_FLUSH
    } t_state;

    t_state                        r_state, n_state;
    logic [hufr_pkg::BYTE_W-1:0]   r_bits, n_bits;
    logic [hufr_pkg::BIT_W-1:0]    r_idx, n_idx;
    logic                          r_last, n_last;
    logic [hufr_pkg::CNT_W-1:0]    r_count, n_count;
    logic [hufr_pkg::NODE_W-1:0]   r_next, n_next;
    logic                          r_collect, n_collect;
    logic [hufr_pkg::TAKEN_W-1:0]  r_taken, n_taken;
    logic [hufr_pkg::SYMBOL_BITS-1:0] r_partial, n_partial;
    logic                          r_finished, n_finished;
    logic [hufr_pkg::ID_W-1:0]     r_tos, n_tos;
    logic [hufr_pkg::ID_W-1:0]     r_nos, n_nos;
    logic                          r_h_valid, n_h_valid;
    hufr_pkg::t_rec                r_h_rec, n_h_rec;
    logic                          r_o_valid, n_o_valid;
    hufr_pkg::t_rec                r_o_rec, n_o_rec;
    logic                          r_o_last, n_o_last;

    logic                          o_free;
    logic                          can_emit;
    logic                          emit;
    hufr_pkg::t_rec                emit_rec;
    logic                          flush;
    logic                          bit_in;
    logic                          inner;
    logic [hufr_pkg::SYMBOL_BITS-1:0] sym_next;
    logic [hufr_pkg::CNT_W-1:0]    cnt_m2;
    logic [hufr_pkg::CNT_W-1:0]    cnt_m3;
    logic                          ram_we;
    logic [hufr_pkg::ID_W-1:0]     ram_rdata;
    logic                          stack_full;
    logic                          nodes_full;

    hufr_ram #(
        .WIDTH (hufr_pkg::ID_W),
        .DEPTH (hufr_pkg::STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (cnt_m2[hufr_pkg::SP_W-1:0]),
        .i_wdata (r_nos),
        .i_raddr (cnt_m3[hufr_pkg::SP_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign o_free     = !r_o_valid || !i_stall;
    assign can_emit   = !r_h_valid || o_free;
    assign cnt_m2     = r_count - hufr_pkg::CNT_W'(2);
    assign cnt_m3     = r_count - hufr_pkg::CNT_W'(3);
    assign bit_in     = r_bits[hufr_pkg::BYTE_W-1];
    assign sym_next   = {r_partial[hufr_pkg::SYMBOL_BITS-2:0], bit_in};
    assign stack_full = (r_count >= hufr_pkg::CNT_W'(hufr_pkg::STACK_DEPTH));
    assign nodes_full = (r_next >= hufr_pkg::NODE_W'(hufr_pkg::MAX_NODES));

    always_comb begin
        n_state    = r_state;
        n_bits     = r_bits;
        n_idx      = r_idx;
        n_last     = r_last;
        n_count    = r_count;
        n_next     = r_next;
        n_collect  = r_collect;
        n_taken    = r_taken;
        n_partial  = r_partial;
        n_finished = r_finished;
        n_tos      = r_tos;
        n_nos      = r_nos;
        n_h_valid  = r_h_valid;
        n_h_rec    = r_h_rec;
        n_o_valid  = r_o_valid;
        n_o_rec    = r_o_rec;
        n_o_last   = r_o_last;
        o_q_pop    = 1'b0;
        emit       = 1'b0;
        emit_rec   = '0;
        flush      = 1'b0;
        inner      = 1'b0;
        ram_we     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_bits  = i_q_byte;
                    n_last  = i_q_end;
                    n_idx   = '0;
                    n_state = S_BIT;
                end
            end
            S_BIT: begin
                if (r_finished) begin
                    n_state = S_END;
                end else if (can_emit) begin
                    n_bits = r_bits << 1;
                    n_idx  = r_idx + hufr_pkg::BIT_W'(1);
                    if (r_collect) begin
                        n_partial = sym_next;
                        n_taken   = r_taken + hufr_pkg::TAKEN_W'(1);
                        if (r_taken == hufr_pkg::TAKEN_W'(hufr_pkg::SYMBOL_BITS - 1)) begin
                            n_collect = 1'b0;
                            n_taken   = '0;
                            n_partial = '0;
                            emit      = 1'b1;
                            if (stack_full || nodes_full) begin
                                emit_rec.kind = hufr_pkg::KIND_ERROR;
                                n_finished    = 1'b1;
                            end else begin
                                emit_rec.kind = hufr_pkg::KIND_LEAF;
                                emit_rec.id   = r_next[hufr_pkg::ID_W-1:0];
                                emit_rec.sym  = hufr_pkg::SYM_W'(sym_next);
                                ram_we        = (r_count >= hufr_pkg::CNT_W'(2));
                                n_nos         = r_tos;
                                n_tos         = r_next[hufr_pkg::ID_W-1:0];
                                n_count       = r_count + hufr_pkg::CNT_W'(1);
                                n_next        = r_next + hufr_pkg::NODE_W'(1);
                            end
                        end
                    end else if (bit_in) begin
                        n_collect = 1'b1;
                        n_taken   = '0;
                        n_partial = '0;
                    end else if (r_count == '0) begin
                        emit          = 1'b1;
                        emit_rec.kind = hufr_pkg::KIND_ERROR;
                        n_finished    = 1'b1;
                    end else if (r_count == hufr_pkg::CNT_W'(1)) begin
                        emit          = 1'b1;
                        emit_rec.kind = hufr_pkg::KIND_DONE;
                        emit_rec.id   = r_tos;
                        n_finished    = 1'b1;
                    end else if (nodes_full) begin
                        emit          = 1'b1;
                        emit_rec.kind = hufr_pkg::KIND_ERROR;
                        n_finished    = 1'b1;
                    end else begin
                        inner          = 1'b1;
                        emit           = 1'b1;
                        emit_rec.kind  = hufr_pkg::KIND_INNER;
                        emit_rec.id    = r_next[hufr_pkg::ID_W-1:0];
                        emit_rec.left  = r_nos;
                        emit_rec.right = r_tos;
                        n_tos          = r_next[hufr_pkg::ID_W-1:0];
                        n_count        = r_count - hufr_pkg::CNT_W'(1);
                        n_next         = r_next + hufr_pkg::NODE_W'(1);
                    end
                    if (inner) begin
                        n_state = S_POP;
                    end else if (n_finished ||
                                 n_idx == hufr_pkg::BIT_W'(hufr_pkg::BYTE_W)) begin
                        n_state = S_END;
                    end
                end
            end
            S_POP: begin
                // next-of-stack refilled from ram
                n_nos   = ram_rdata;
                n_state = (r_idx == hufr_pkg::BIT_W'(hufr_pkg::BYTE_W)) ? S_END : S_BIT;
            end
            S_END: begin
                if (!r_last) begin
                    n_state = S_FLUSH;
                end else if (r_finished || can_emit) begin
                    if (!r_finished) begin
                        emit = 1'b1;
                        if (r_count == '0) begin
                            emit_rec.kind = hufr_pkg::KIND_ERROR;
                        end else begin
                            emit_rec.kind = hufr_pkg::KIND_DONE;
                            emit_rec.id   = r_tos;
                        end
                    end
                    n_count    = '0;
                    n_next     = '0;
                    n_collect  = 1'b0;
                    n_taken    = '0;
                    n_partial  = '0;
                    n_finished = 1'b0;
                    n_state    = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!r_h_valid) begin
                    n_state = S_IDLE;
                end else if (o_free) begin
                    flush   = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // output register drains, hold register feeds it
        if (r_o_valid && !i_stall) begin
            n_o_valid = 1'b0;
        end
        if (emit) begin
            if (r_h_valid) begin
                n_o_valid = 1'b1;
                n_o_rec   = r_h_rec;
                n_o_last  = 1'b0;
            end
            n_h_valid = 1'b1;
            n_h_rec   = emit_rec;
        end
        if (flush) begin
            n_o_valid = 1'b1;
            n_o_rec   = r_h_rec;
            n_o_last  = 1'b1;
            n_h_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_idx      <= '0;
            r_last     <= 1'b0;
            r_count    <= '0;
            r_next     <= '0;
            r_collect  <= 1'b0;
            r_taken    <= '0;
            r_partial  <= '0;
            r_finished <= 1'b0;
            r_h_valid  <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_last     <= n_last;
            r_count    <= n_count;
            r_next     <= n_next;
            r_collect  <= n_collect;
            r_taken    <= n_taken;
            r_partial  <= n_partial;
            r_finished <= n_finished;
            r_h_valid  <= n_h_valid;
            r_o_valid  <= n_o_valid;
        end
        r_bits   <= n_bits;
        r_tos    <= n_tos;
        r_nos    <= n_nos;
        r_h_rec  <= n_h_rec;
        r_o_rec  <= n_o_rec;
        r_o_last <= n_o_last;
    end

    assign o_valid       = r_o_valid;
    assign o_record_kind = r_o_rec.kind;
    assign o_node_id     = r_o_rec.id;
    assign o_leaf_symbol = r_o_rec.sym;
    assign o_left_child  = r_o_rec.left;
    assign o_right_child = r_o_rec.right;
    assign o_run_last    = r_o_last;

endmodule

FILE: sv/huffman_tree_header_rebuild.sv
// huffman_tree_header_rebuild: top level, input byte queue feeding the bit
// engine; depends on hufr_pkg, hufr_in_queue, hufr_engine, hufr_ram
//
// input channel: i_valid / o_stall carry one packed header byte
// (i_header_byte, bits used msb first) and i_stream_end, set on the
// final byte of a header. a two-entry queue takes bytes while the engine
// is still busy with an earlier one.
// output channel: o_valid / i_stall carry node records (leaf, internal node,
// done with root, error). o_run_last marks the last record of each byte;
// a byte that yields no record gives no transfer.
// throughput: one header bit per cycle while the output path has room; each
// byte also passes through fetch, end and hand-off states, and each internal
// node adds a step that refills the second stack entry from the stack ram's
// registered read port.
// each record waits in the hold register and moves to the output register
// when the next record is found; the last record of a byte moves in the
// hand-off state, so earlier records of the byte follow one record behind.
// reset clears the queue, the stack count, the node counter and the symbol
// collector; the stack ram needs no clearing.
// when the receiver stalls, the output register and one hold register fill,
// then the bit engine waits, then the queue fills and o_stall rises.
module huffman_tree_header_rebuild (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [hufr_pkg::BYTE_W-1:0] i_header_byte,
    input  logic                        i_stream_end,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [hufr_pkg::KIND_W-1:0] o_record_kind,
    output logic [hufr_pkg::ID_W-1:0]   o_node_id,
    output logic [hufr_pkg::SYM_W-1:0]  o_leaf_symbol,
    output logic [hufr_pkg::ID_W-1:0]   o_left_child,
    output logic [hufr_pkg::ID_W-1:0]   o_right_child,
    output logic                        o_run_last
);

    logic                        q_valid;
    logic                        q_pop;
    logic [hufr_pkg::BYTE_W-1:0] q_byte;
    logic                        q_end;

    hufr_in_queue u_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_header_byte (i_header_byte),
        .i_stream_end  (i_stream_end),
        .o_q_valid     (q_valid),
        .i_q_pop       (q_pop),
        .o_q_byte      (q_byte),
        .o_q_end       (q_end)
    );

    hufr_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .o_q_pop       (q_pop),
        .i_q_byte      (q_byte),
        .i_q_end       (q_end),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_record_kind (o_record_kind),
        .o_node_id     (o_node_id),
        .o_leaf_symbol (o_leaf_symbol),
        .o_left_child  (o_left_child),
        .o_right_child (o_right_child),
        .o_run_last    (o_run_last)
    );

endmodule
